// File: rtl/idxpq_pkg.sv
// Package for the indexed min-priority queue: widths, opcodes, heap entry
// type and the ordering function. No dependencies.
`default_nettype none
package idxpq_pkg;

  localparam int Capacity = 1024;
  localparam int SlotW    = $clog2(Capacity);
  localparam int CntW     = SlotW + 1;
  localparam int KeyW     = 32;
  localparam int OpW      = 3;

  localparam logic [OpW-1:0] OpInsert   = 3'd0;
  localparam logic [OpW-1:0] OpExtract  = 3'd1;
  localparam logic [OpW-1:0] OpDecrease = 3'd2;
  localparam logic [OpW-1:0] OpGet      = 3'd3;
  localparam logic [OpW-1:0] OpClear    = 3'd4;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  key;
  } heap_ent_t;

  // Store access bundle: two heap reads, one position read, one write each.
  typedef struct packed {
    logic [SlotW-1:0] hra;
    logic [SlotW-1:0] hrb;
    logic [SlotW-1:0] pra;
    logic             hwe;
    logic [SlotW-1:0] hwa;
    heap_ent_t        hwd;
    logic             pwe;
    logic [SlotW-1:0] pwa;
    logic [SlotW-1:0] pwd;
  } mem_req_t;

  // a orders before b: smaller key, ties to the lower slot
  function automatic logic ent_before(heap_ent_t a, heap_ent_t b);
    logic r;
    if (a.key != b.key) begin
      r = (a.key < b.key);
    end else begin
      r = (a.slot < b.slot);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/idxpq_store.sv
// Queue storage: heap array (position -> slot, key) and position array
// (slot -> heap position). Uses idxpq_pkg.
`default_nettype none
module idxpq_store (
  input  wire                      clk_i,
  input  idxpq_pkg::mem_req_t      req_i,
  output idxpq_pkg::heap_ent_t     hrda_o,
  output idxpq_pkg::heap_ent_t     hrdb_o,
  output logic [idxpq_pkg::SlotW-1:0] prd_o
);

  idxpq_pkg::heap_ent_t            heap_mem [idxpq_pkg::Capacity];
  logic [idxpq_pkg::SlotW-1:0]     pos_mem  [idxpq_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.hwe) begin
      heap_mem[req_i.hwa] <= req_i.hwd;
    end
    hrda_o <= heap_mem[req_i.hra];
    hrdb_o <= heap_mem[req_i.hrb];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pwe) begin
      pos_mem[req_i.pwa] <= req_i.pwd;
    end
    prd_o <= pos_mem[req_i.pra];
  end

endmodule
`default_nettype wire

// File: rtl/indexed_min_priority_queue.sv
// Indexed min-priority queue, top level: operation sequencer, sift loops
// and result register. Uses idxpq_pkg and idxpq_store.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | opcode_i, slot_i, key_in_i
//  out     | output    | out_valid_o/out_ready_i | status_o, slot_out_o,
//          |           |                         | key_out_o
//
// One transaction at a time. Get and rejected insert, decrease or get pass
// through StLk1 and StLk2 to StDone; clear, unused opcodes and extract on an
// empty queue go straight to StDone. Insert/decrease sift up through StUp and
// StUpC per level, extract sifts down through StDn and StDnC per level; the
// worst case is set by the single read-compare-write loop on the heap memory.
// After reset a clearing pass over every position zeroes the position memory
// (in_ready_o low meanwhile). Slot validity is then checked as pos < count
// and heap[pos].slot == slot, so clear only resets the count.
// A finished result waits in StDone while the output register is held.
`default_nettype none
module indexed_min_priority_queue (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [idxpq_pkg::OpW-1:0]      opcode_i,
  input  wire  [idxpq_pkg::SlotW-1:0]    slot_i,
  input  wire  [idxpq_pkg::KeyW-1:0]     key_in_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           status_o,
  output logic [idxpq_pkg::SlotW-1:0]    slot_out_o,
  output logic [idxpq_pkg::KeyW-1:0]     key_out_o
);

  localparam int SlotW = idxpq_pkg::SlotW;
  localparam int CntW  = idxpq_pkg::CntW;
  localparam int KeyW  = idxpq_pkg::KeyW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StLk1  = 4'd1;  // position read returned
  localparam logic [3:0] StLk2  = 4'd2;  // heap entry at that position returned
  localparam logic [3:0] StUp   = 4'd3;  // sift up: fetch parent
  localparam logic [3:0] StUpC  = 4'd4;  // sift up: compare with parent
  localparam logic [3:0] StEx   = 4'd5;  // root and last entry returned
  localparam logic [3:0] StDn   = 4'd6;  // sift down: fetch children
  localparam logic [3:0] StDnC  = 4'd7;  // sift down: compare children
  localparam logic [3:0] StDone = 4'd8;
  localparam logic [3:0] StInit = 4'd9;  // clearing pass over the position memory

  logic [3:0]                    state_q, state_d;
  logic [SlotW-1:0]              init_q, init_d;
  logic [idxpq_pkg::OpW-1:0]     op_q, op_d;
  logic [SlotW-1:0]              slot_q, slot_d;
  logic [KeyW-1:0]               key_q, key_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [SlotW-1:0]              c_q, c_d;     // current hole position
  logic [SlotW-1:0]              pos_q, pos_d;
  idxpq_pkg::heap_ent_t          item_q, item_d;
  logic                          rst_q, rst_d;
  logic [SlotW-1:0]              rslot_q, rslot_d;
  logic [KeyW-1:0]               rkey_q, rkey_d;
  logic                          ovalid_q, ovalid_d;
  logic                          ostat_q, ostat_d;
  logic [SlotW-1:0]              oslot_q, oslot_d;
  logic [KeyW-1:0]               okey_q, okey_d;

  idxpq_pkg::mem_req_t           req;
  idxpq_pkg::heap_ent_t          hrda, hrdb;
  logic [SlotW-1:0]              prd;

  idxpq_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .hrda_o (hrda),
    .hrdb_o (hrdb),
    .prd_o  (prd)
  );

  logic                          in_acc;
  logic                          slot_ok;
  logic [CntW:0]                 lchild, rchild;
  logic                          r_ok;
  logic                          pick_b;
  idxpq_pkg::heap_ent_t          best;
  logic [SlotW-1:0]              best_idx;
  logic [CntW-1:0]               cnt_dec;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_ok    = ({1'b0, pos_q} < cnt_q) && (hrda.slot == slot_q);
  assign lchild     = {1'b0, c_q, 1'b1};
  assign rchild     = lchild + 1'b1;
  assign r_ok       = rchild < {1'b0, cnt_q};
  assign pick_b     = r_ok && idxpq_pkg::ent_before(hrdb, hrda);
  assign best       = pick_b ? hrdb : hrda;
  assign best_idx   = pick_b ? rchild[SlotW-1:0] : lchild[SlotW-1:0];
  assign cnt_dec    = cnt_q - 1'b1;

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    op_d     = op_q;
    slot_d   = slot_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    c_d      = c_q;
    pos_d    = pos_q;
    item_d   = item_q;
    rst_d    = rst_q;
    rslot_d  = rslot_q;
    rkey_d   = rkey_q;
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    oslot_d  = oslot_q;
    okey_d   = okey_q;
    req      = '0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StInit: begin
        req.pwe = 1'b1;
        req.pwa = init_q;
        req.pwd = '0;
        init_d  = init_q + 1'b1;
        if (init_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        req.pra = slot_i;
        req.hra = '0;
        req.hrb = cnt_dec[SlotW-1:0];
        if (in_acc) begin
          op_d    = opcode_i;
          slot_d  = slot_i;
          key_d   = key_in_i;
          rst_d   = 1'b1;
          rslot_d = '0;
          rkey_d  = '0;
          state_d = StDone;
          case (opcode_i)
            idxpq_pkg::OpInsert, idxpq_pkg::OpDecrease, idxpq_pkg::OpGet: begin
              state_d = StLk1;
            end
            idxpq_pkg::OpExtract: begin
              if (cnt_q != '0) begin
                state_d = StEx;
              end
            end
            idxpq_pkg::OpClear: begin
              cnt_d = '0;
              rst_d = 1'b0;
            end
            default: begin
              rst_d = 1'b1;
            end
          endcase
        end
      end
      StLk1: begin
        req.hra = prd;
        pos_d   = prd;
        state_d = StLk2;
      end
      StLk2: begin
        state_d = StDone;
        item_d  = '{slot: slot_q, key: key_q};
        case (op_q)
          idxpq_pkg::OpInsert: begin
            if (!slot_ok && (cnt_q < CntW'(idxpq_pkg::Capacity))) begin
              c_d     = cnt_q[SlotW-1:0];
              cnt_d   = cnt_q + 1'b1;
              state_d = StUp;
            end
          end
          idxpq_pkg::OpDecrease: begin
            if (slot_ok && (key_q <= hrda.key)) begin
              c_d     = pos_q;
              state_d = StUp;
            end
          end
          idxpq_pkg::OpGet: begin
            if (slot_ok) begin
              rst_d   = 1'b0;
              rslot_d = slot_q;
              rkey_d  = hrda.key;
            end
          end
          default: begin
            rst_d = 1'b1;
          end
        endcase
      end
      StUp: begin
        req.hra = SlotW'((c_q - 1'b1) >> 1);
        if (c_q == '0) begin
          req.hwe = 1'b1;
          req.hwa = c_q;
          req.hwd = item_q;
          req.pwe = 1'b1;
          req.pwa = item_q.slot;
          req.pwd = c_q;
          rst_d   = 1'b0;
          state_d = StDone;
        end else begin
          state_d = StUpC;
        end
      end
      StUpC: begin
        req.hwe = 1'b1;
        req.hwa = c_q;
        req.pwe = 1'b1;
        req.pwd = c_q;
        if (idxpq_pkg::ent_before(item_q, hrda)) begin
          req.hwd = hrda;
          req.pwa = hrda.slot;
          c_d     = SlotW'((c_q - 1'b1) >> 1);
          state_d = StUp;
        end else begin
          req.hwd = item_q;
          req.pwa = item_q.slot;
          rst_d   = 1'b0;
          state_d = StDone;
        end
      end
      StEx: begin
        rst_d   = 1'b0;
        rslot_d = hrda.slot;
        rkey_d  = hrda.key;
        cnt_d   = cnt_dec;
        item_d  = hrdb;
        c_d     = '0;
        state_d = (cnt_dec == '0) ? StDone : StDn;
      end
      StDn: begin
        req.hra = lchild[SlotW-1:0];
        req.hrb = rchild[SlotW-1:0];
        if (lchild >= {1'b0, cnt_q}) begin
          req.hwe = 1'b1;
          req.hwa = c_q;
          req.hwd = item_q;
          req.pwe = 1'b1;
          req.pwa = item_q.slot;
          req.pwd = c_q;
          state_d = StDone;
        end else begin
          state_d = StDnC;
        end
      end
      StDnC: begin
        req.hwe = 1'b1;
        req.hwa = c_q;
        req.pwe = 1'b1;
        req.pwd = c_q;
        if (idxpq_pkg::ent_before(best, item_q)) begin
          req.hwd = best;
          req.pwa = best.slot;
          c_d     = best_idx;
          state_d = StDn;
        end else begin
          req.hwd = item_q;
          req.pwa = item_q.slot;
          state_d = StDone;
        end
      end
      StDone: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = rst_q;
          oslot_d  = rst_q ? '0 : rslot_q;
          okey_d   = rst_q ? '0 : rkey_q;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      init_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    slot_q  <= slot_d;
    key_q   <= key_d;
    c_q     <= c_d;
    pos_q   <= pos_d;
    item_q  <= item_d;
    rst_q   <= rst_d;
    rslot_q <= rslot_d;
    rkey_q  <= rkey_d;
    ostat_q <= ostat_d;
    oslot_q <= oslot_d;
    okey_q  <= okey_d;
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign slot_out_o  = oslot_q;
  assign key_out_o   = okey_q;

  // occupancy never exceeds the slot count
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(idxpq_pkg::Capacity))
    else $error("occupancy above capacity");

  // heap writes land inside the occupied region
  a_hwr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.hwe |-> ({1'b0, req.hwa} < cnt_q))
    else $error("heap write beyond occupancy");

  // a rejected transaction reports zero payload
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q) |-> (oslot_q == '0 && okey_q == '0))
    else $error("non-zero payload on rejected result");

  // a released result in ST_DONE appears on the output next cycle
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && (!ovalid_q || out_ready_i)) |=> (ovalid_q && state_q == StIdle))
    else $error("result not delivered");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for indexed_min_priority_queue: directed and random
// operations against a slot-array predictor. Depends on idxpq_pkg and the RTL.
`default_nettype none
module tb_top;
  import idxpq_pkg::*;

  localparam logic [OpW-1:0] OpSpareLo  = 3'd5;
  localparam logic [OpW-1:0] OpSpareMid = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi  = 3'd7;
  localparam int NumRandom = 1500;

  typedef struct {
    logic             status;
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  key;
  } pq_result_t;

  // Predictor: a flat key store plus occupancy flags. The minimum is found by
  // a full scan, which gives the same order as any heap with lowest-slot ties.
  class pq_scoreboard;
    logic [KeyW-1:0] keys[Capacity];
    bit              live[Capacity];
    int              count;
    int              errors;
    pq_result_t      pending_q[$];

    function new();
      count  = 0;
      errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void note_input(logic [OpW-1:0] op, logic [SlotW-1:0] s,
                             logic [KeyW-1:0] k);
      pq_result_t r;
      int best;
      r = '{1'b1, '0, '0};
      best = -1;
      case (op)
        OpInsert: begin
          if (!live[s] && count < Capacity) begin
            keys[s] = k;
            live[s] = 1;
            count++;
            r.status = 0;
          end
        end
        OpExtract: begin
          for (int i = 0; i < Capacity; i++) begin
            if (live[i] && (best < 0 || keys[i] < keys[best])) best = i;
          end
          if (best >= 0) begin
            r = '{1'b0, best[SlotW-1:0], keys[best]};
            live[best] = 0;
            count--;
          end
        end
        OpDecrease: begin
          if (live[s] && k <= keys[s]) begin
            keys[s] = k;
            r.status = 0;
          end
        end
        OpGet: begin
          if (live[s]) r = '{1'b0, s, keys[s]};
        end
        OpClear: begin
          foreach (live[i]) live[i] = 0;
          count = 0;
          r.status = 0;
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic st, logic [SlotW-1:0] s, logic [KeyW-1:0] k);
      pq_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d key %h", st, s, k);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (s !== e.slot) begin
        $error("slot_out: expected %0d, got %0d", e.slot, s);
        errors++;
      end
      if (k !== e.key) begin
        $error("key_out: expected %h, got %h", e.key, k);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             in_valid_i = 0;
  logic             in_ready_o;
  logic [OpW-1:0]   opcode_i = '0;
  logic [SlotW-1:0] slot_i = '0;
  logic [KeyW-1:0]  key_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 0;
  logic             status_o;
  logic [SlotW-1:0] slot_out_o;
  logic [KeyW-1:0]  key_out_o;

  pq_scoreboard sb = new();
  bit           hold_req = 0;
  bit           hold_done = 0;
  logic [SlotW-1:0] slot_mask = '1;
  bit           tie_keys = 0;

  indexed_min_priority_queue dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .slot_i, .key_in_i,
    .out_valid_o, .out_ready_i, .status_o, .slot_out_o, .key_out_o
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Transaction monitors sample pre-edge values at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(opcode_i, slot_i, key_in_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, slot_out_o, key_out_o);
  end

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(logic [OpW-1:0] op, logic [SlotW-1:0] s, logic [KeyW-1:0] k);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i   <= op;
    slot_i     <= s;
    key_in_i   <= k;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender stops offering and waits until every result has come back
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [OpW-1:0]   op;
    logic [SlotW-1:0] s;
    logic [KeyW-1:0]  k;
    longint unsigned  cur;
    int r;
    r = $urandom_range(0, 99);
    if (r < 38)      op = OpInsert;
    else if (r < 62) op = OpExtract;
    else if (r < 78) op = OpDecrease;
    else if (r < 94) op = OpGet;
    else if (r < 96) op = OpClear;
    else             op = OpW'($urandom_range(OpSpareLo, OpSpareHi));
    s = SlotW'($urandom) & slot_mask;
    k = tie_keys ? KeyW'($urandom_range(0, 7)) : KeyW'($urandom);
    // Decreases are mostly well-formed: a live slot and a key not above its own
    if (op == OpDecrease && sb.live[s] && $urandom_range(0, 99) < 80) begin
      cur = sb.keys[s];
      k = KeyW'(cur - ({32'd0, $urandom} % (cur + 1)));
    end
    send_op(op, s, k);
  endtask

  // Receiver: random ready with short and long gaps; one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_req  = 0;
        hold_done = 1;
      end else begin
        out_ready_i <= 1;
        n = $urandom_range(1, 50);
        repeat (n) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty queue, extremes, duplicates, ties, decreases, spares
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpGet,      10'd1023, 32'h0);
    send_op(OpDecrease, 10'd5,    32'h0);
    send_op(OpInsert,   10'd1023, 32'hFFFF_FFFF);
    send_op(OpInsert,   10'd0,    32'h0001_0000);
    send_op(OpInsert,   10'd0,    32'h0);
    send_op(OpInsert,   10'd512,  32'h0001_0000);
    send_op(OpInsert,   10'd7,    32'h0001_0000);
    send_op(OpGet,      10'd1023, 32'h0);
    send_op(OpDecrease, 10'd7,    32'h0002_0000);
    send_op(OpDecrease, 10'd7,    32'h0001_0000);
    send_op(OpDecrease, 10'd1023, 32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpSpareLo,  10'd3,    32'h1234_5678);
    send_op(OpSpareMid, 10'd1023, 32'hFFFF_FFFF);
    send_op(OpSpareHi,  10'd0,    32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    send_op(OpInsert,   10'd300,  32'h8000_0000);
    send_op(OpClear,    10'd0,    32'h0);
    send_op(OpGet,      10'd300,  32'h0);
    send_op(OpExtract,  10'd0,    32'h0);
    drain();

    // Random: each phase draws a slot pool (small or full range) and a key mode (tie-heavy or full)
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 250 == 0) begin
        slot_mask = ($urandom_range(0, 3) == 0) ? '1 : SlotW'(15);
        tie_keys  = $urandom_range(0, 1);
      end
      if (i == 400) hold_req = 1;
      if (i == 900) drain();
      send_random();
    end
    drain();
    while (!hold_done) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
